// ===== design/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the stepper position controller
// Command codes, register indexes, direction codes and the state and
// configuration records passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int POSITION_BITS = 16;
  localparam int MAX_PHASES    = 8;
  localparam int START_STEPS   = 16;
  localparam int PERIOD_BITS   = 16;
  localparam int PHASE_BITS    = 3;
  localparam int COUNT_BITS    = 4;
  localparam int COIL_BITS     = 4;
  localparam int TABLE_BITS    = COIL_BITS * MAX_PHASES;
  localparam int STEPS_BITS    = 8;
  localparam int CMD_BITS      = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 48;

  localparam logic [PERIOD_BITS-1:0] TICK_MAX   = '1;
  localparam logic [STEPS_BITS-1:0]  STEPS_MAX  = '1;
  localparam logic [STEPS_BITS-1:0]  START_LAST = STEPS_BITS'(START_STEPS);
  localparam logic [COUNT_BITS-1:0]  PHASES_MAX = COUNT_BITS'(MAX_PHASES);
  localparam logic [COUNT_BITS-1:0]  PHASES_RST = 4'd4;

  typedef logic signed [POSITION_BITS-1:0] pos_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_STEP_TICK    = 3'd0,
    CMD_SET_TARGET   = 3'd1,
    CMD_STOP         = 3'd2,
    CMD_OFFSET       = 3'd3,
    CMD_HOME_START   = 3'd4,
    CMD_HOME_ABORT   = 3'd5,
    CMD_HOME_TICK    = 3'd6
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_PERIOD = 3'd0,
    REG_RUN_PERIOD   = 3'd1,
    REG_PHASE_COUNT  = 3'd2,
    REG_PATTERN      = 3'd3,
    REG_MAX_POS      = 3'd4,
    REG_MIN_POS      = 3'd5,
    REG_ORIGIN_POS   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  localparam logic [1:0] HOME_MAX    = 2'd0;
  localparam logic [1:0] HOME_MIN    = 2'd1;
  localparam logic [1:0] HOME_ORIGIN = 2'd2;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] start_period;
    logic [PERIOD_BITS-1:0] run_period;
    logic [COUNT_BITS-1:0]  phase_count;
    logic [TABLE_BITS-1:0]  pattern_table;
    pos_t                   max_position;
    pos_t                   min_position;
    pos_t                   origin_position;
  } cfg_t;

  typedef struct packed {
    pos_t                   current_pos;
    pos_t                   target_pos;
    logic [PHASE_BITS-1:0]  phase_index;
    logic [PERIOD_BITS-1:0] tick_counter;
    logic [STEPS_BITS-1:0]  steps_since_start;
    dir_t                   move_direction;
    logic                   moving;
    logic [COIL_BITS-1:0]   coil_out;
    logic                   homing_on;
    logic [1:0]             homing_step;
  } state_t;

endpackage

// ===== design/spc_step.sv =====
// ----------------------------------------------------------------------------
// spc_step: next-state logic of the stepper position controller
// Applies one command to the controller state and gives the state after it.
// ----------------------------------------------------------------------------
module spc_step (
  input  spc_pkg::state_t                   state,
  input  spc_pkg::cfg_t                     cfg,
  input  logic [spc_pkg::CMD_BITS-1:0]      command,
  input  spc_pkg::pos_t                     value,
  input  logic                              force_req,
  output spc_pkg::state_t                   state_next
);

  logic [spc_pkg::COUNT_BITS-1:0]  phases;
  logic [spc_pkg::PHASE_BITS-1:0]  phase_last;
  logic [spc_pkg::PERIOD_BITS-1:0] tick_inc;
  logic [spc_pkg::PERIOD_BITS-1:0] period;
  logic                            due;
  logic [spc_pkg::PHASE_BITS-1:0]  phase_fwd;
  logic [spc_pkg::PHASE_BITS-1:0]  phase_rev;
  logic [spc_pkg::PHASE_BITS-1:0]  phase_new;
  logic                            go_rev;
  logic signed [spc_pkg::POSITION_BITS:0] offset_sum;
  spc_pkg::pos_t                   offset_pos;
  spc_pkg::pos_t                   home_stop;

  // Clamp the phase count to 1..MAX_PHASES
  always_comb begin
    if (cfg.phase_count == '0) begin
      phases = spc_pkg::COUNT_BITS'(1);
    end else if (cfg.phase_count > spc_pkg::PHASES_MAX) begin
      phases = spc_pkg::PHASES_MAX;
    end else begin
      phases = cfg.phase_count;
    end
  end
  assign phase_last = spc_pkg::PHASE_BITS'(phases - spc_pkg::COUNT_BITS'(1));

  // Saturating tick count and the period for this part of the move
  assign tick_inc = (state.tick_counter != spc_pkg::TICK_MAX) ?
                    state.tick_counter + spc_pkg::PERIOD_BITS'(1) : state.tick_counter;
  assign period   = (state.steps_since_start <= spc_pkg::START_LAST) ?
                    cfg.start_period : cfg.run_period;
  assign due      = tick_inc > period;

  // Phase index one step each way, wrapping at the phase count
  assign go_rev    = state.target_pos < state.current_pos;
  assign phase_rev = (state.phase_index != '0) ?
                     state.phase_index - spc_pkg::PHASE_BITS'(1) : phase_last;
  assign phase_fwd = (state.phase_index < phase_last) ?
                     state.phase_index + spc_pkg::PHASE_BITS'(1) : '0;
  assign phase_new = go_rev ? phase_rev : phase_fwd;

  // Offset: widen the sum, then clamp against max first and min second
  assign offset_sum = {state.target_pos[spc_pkg::POSITION_BITS-1], state.target_pos}
                    + {value[spc_pkg::POSITION_BITS-1], value};
  always_comb begin
    if (offset_sum >
        $signed({cfg.max_position[spc_pkg::POSITION_BITS-1], cfg.max_position})) begin
      offset_pos = cfg.max_position;
    end else if (offset_sum <
                 $signed({cfg.min_position[spc_pkg::POSITION_BITS-1],
                          cfg.min_position})) begin
      offset_pos = cfg.min_position;
    end else begin
      offset_pos = offset_sum[spc_pkg::POSITION_BITS-1:0];
    end
  end

  // Stop of the current homing stage; stage three acts as origin
  always_comb begin
    case (state.homing_step)
      spc_pkg::HOME_MAX: home_stop = cfg.max_position;
      spc_pkg::HOME_MIN: home_stop = cfg.min_position;
      default:           home_stop = cfg.origin_position;
    endcase
  end

  // Apply the command
  always_comb begin
    state_next = state;
    case (command)
      spc_pkg::CMD_STEP_TICK: begin
        if (state.current_pos == state.target_pos) begin
          state_next.tick_counter      = '0;
          state_next.steps_since_start = '0;
          state_next.move_direction    = spc_pkg::DIR_STOP;
          state_next.moving            = 1'b0;
          state_next.coil_out          = '0;
        end else if (!due) begin
          state_next.tick_counter = tick_inc;
        end else begin
          state_next.tick_counter = '0;
          if (state.steps_since_start != spc_pkg::STEPS_MAX) begin
            state_next.steps_since_start =
              state.steps_since_start + spc_pkg::STEPS_BITS'(1);
          end
          if (go_rev) begin
            state_next.move_direction = spc_pkg::DIR_REV;
            state_next.current_pos    = state.current_pos - spc_pkg::pos_t'(1);
          end else begin
            state_next.move_direction = spc_pkg::DIR_FWD;
            state_next.current_pos    = state.current_pos + spc_pkg::pos_t'(1);
          end
          state_next.phase_index = phase_new;
          state_next.moving      = 1'b1;
          state_next.coil_out    = cfg.pattern_table[phase_new*spc_pkg::COIL_BITS +:
                                                     spc_pkg::COIL_BITS];
        end
      end
      spc_pkg::CMD_SET_TARGET: begin
        if (force_req || !state.moving) begin
          state_next.target_pos = value;
        end
      end
      spc_pkg::CMD_STOP: begin
        state_next.target_pos = state.current_pos;
      end
      spc_pkg::CMD_OFFSET: begin
        state_next.target_pos  = offset_pos;
        state_next.current_pos = offset_pos;
      end
      spc_pkg::CMD_HOME_START: begin
        state_next.homing_on   = 1'b1;
        state_next.homing_step = spc_pkg::HOME_MAX;
      end
      spc_pkg::CMD_HOME_ABORT: begin
        state_next.homing_on = 1'b0;
      end
      spc_pkg::CMD_HOME_TICK: begin
        if (state.homing_on) begin
          if (state.current_pos != home_stop) begin
            state_next.target_pos = home_stop;
          end else if (state.homing_step < spc_pkg::HOME_ORIGIN) begin
            state_next.homing_step = state.homing_step + 2'd1;
          end else begin
            state_next.homing_on = 1'b0;
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

// ===== design/stepper_position_controller.sv =====
// ----------------------------------------------------------------------------
// stepper_position_controller: stepper motor position controller with homing
// Steps a motor toward a target position on step ticks, with a slow start
// period, a phase pattern table, position offset with limits and homing.
// ----------------------------------------------------------------------------
// The block takes one command item per clock cycle while the result side keeps up
// and returns one result item for each, showing the controller state after that
// command. A command is held in an input register until the output register can
// load, passes through the single-pass step logic and lands in the output
// register, where its result is offered; the rate of one item per cycle is set
// by that step logic, which computes the whole next state combinationally. The output
// register lets a new command enter while a finished result still waits.
// Configuration writes are taken at once and must be issued only while the block is idle.
module stepper_position_controller (
  input  logic                                clk,
  input  logic                                rst,
  // input item
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [spc_pkg::IN_DATA_BITS-1:0]    s_tdata,  // value[15:0], force_req[16], zero
  input  logic [spc_pkg::CMD_BITS-1:0]        s_tuser,  // command[2:0]
  // result item
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [spc_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // coil_pattern[3:0], running[4],
                                                        // direction[6:5], position[22:7],
                                                        // target[38:23], homing_active[39],
                                                        // homing_stage[41:40], zero
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [spc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  spc_pkg::cfg_t                     cfg;
  spc_pkg::state_t                   state;
  spc_pkg::state_t                   state_next;
  logic                              in_valid;
  logic [spc_pkg::CMD_BITS-1:0]      in_command;
  spc_pkg::pos_t                     in_value;
  logic                              in_force;
  logic                              in_accept;
  logic                              out_load;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_period    <= '0;
      cfg.run_period      <= '0;
      cfg.phase_count     <= spc_pkg::PHASES_RST;
      cfg.pattern_table   <= '0;
      cfg.max_position    <= '0;
      cfg.min_position    <= '0;
      cfg.origin_position <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spc_pkg::REG_START_PERIOD:
          cfg.start_period <= cfg_data[spc_pkg::PERIOD_BITS-1:0];
        spc_pkg::REG_RUN_PERIOD:
          cfg.run_period <= cfg_data[spc_pkg::PERIOD_BITS-1:0];
        spc_pkg::REG_PHASE_COUNT:
          cfg.phase_count <= cfg_data[spc_pkg::COUNT_BITS-1:0];
        spc_pkg::REG_PATTERN:
          cfg.pattern_table <= cfg_data[spc_pkg::TABLE_BITS-1:0];
        spc_pkg::REG_MAX_POS:
          cfg.max_position <= cfg_data[spc_pkg::POSITION_BITS-1:0];
        spc_pkg::REG_MIN_POS:
          cfg.min_position <= cfg_data[spc_pkg::POSITION_BITS-1:0];
        spc_pkg::REG_ORIGIN_POS:
          cfg.origin_position <= cfg_data[spc_pkg::POSITION_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the input register drains whenever the output register can load
  assign out_load  = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || out_load;
  assign in_accept = s_tvalid && s_tready;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_accept) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_command <= s_tuser;
      in_value   <= s_tdata[spc_pkg::POSITION_BITS-1:0];
      in_force   <= s_tdata[spc_pkg::POSITION_BITS];
    end
  end

  spc_step u_step (
    .state      (state),
    .cfg        (cfg),
    .command    (in_command),
    .value      (in_value),
    .force_req  (in_force),
    .state_next (state_next)
  );

  // Advance the controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (out_load) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0,
                  state_next.homing_step,
                  state_next.homing_on,
                  state_next.target_pos,
                  state_next.current_pos,
                  state_next.move_direction,
                  state_next.moving,
                  state_next.coil_out};
    end
  end

`ifndef SYNTH
  // A moving motor always has a direction
  assert property (@(posedge clk) disable iff (rst)
    state.moving |-> (state.move_direction != spc_pkg::DIR_STOP))
    else $error("moving with no direction");

  // Coils are off whenever the motor is not moving
  assert property (@(posedge clk) disable iff (rst)
    !state.moving |-> (state.coil_out == '0))
    else $error("coils driven while stopped");

  // Homing never reaches a fourth stage
  assert property (@(posedge clk) disable iff (rst)
    state.homing_step != 2'd3)
    else $error("homing stage out of range");

  // A held item that cannot drain stays held
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_load) |=> in_valid)
    else $error("held item lost");
`endif

endmodule

// ===== verif/tb_stepper_position_controller.sv =====
// ----------------------------------------------------------------------------
// tb_stepper_position_controller: self-checking bench of the stepper controller
// Drives command items and register writes into the controller and mirrors
// its motion, offset and homing behavior in a tracker object. Every result
// item is compared field by field with the tracker's prediction. A short
// directed pass is followed by randomized phases that vary the configuration
// and the idling on both sides.
// ----------------------------------------------------------------------------
module tb_stepper_position_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [spc_pkg::CMD_BITS-1:0] CMD_UNUSED  = 3'd7;
  localparam int                           CYCLE_LIMIT = 20000;
  localparam int                           PHASES      = 8;
  localparam int                           PHASE_ITEMS = 12;

  // result item layout, lowest field last
  typedef struct packed {
    logic [5:0]    pad;
    logic [1:0]    stage;
    logic          homing;
    spc_pkg::pos_t target;
    spc_pkg::pos_t position;
    logic [1:0]    direction;
    logic          running;
    logic [3:0]    coil;
  } status_t;

  // Mirror of the controller: configuration, motion state, expected results
  class motion_tracker;
    logic [15:0]   start_period;
    logic [15:0]   run_period;
    logic [3:0]    phase_count;
    logic [31:0]   pattern;
    spc_pkg::pos_t max_pos;
    spc_pkg::pos_t min_pos;
    spc_pkg::pos_t origin_pos;

    spc_pkg::pos_t cur_pos;
    spc_pkg::pos_t tgt_pos;
    logic [2:0]    phase;
    logic [15:0]   tick;
    logic [7:0]    steps;
    spc_pkg::dir_t dir;
    logic          moving;
    logic [3:0]    coil;
    logic          homing_on;
    logic [1:0]    home_stage;

    status_t       pending_status[$];
    int unsigned   mismatches;

    function new();
      start_period = '0;
      run_period   = '0;
      phase_count  = spc_pkg::PHASES_RST;
      pattern      = '0;
      max_pos      = '0;
      min_pos      = '0;
      origin_pos   = '0;
      cur_pos      = '0;
      tgt_pos      = '0;
      phase        = '0;
      tick         = '0;
      steps        = '0;
      dir          = spc_pkg::DIR_STOP;
      moving       = 1'b0;
      coil         = '0;
      homing_on    = 1'b0;
      home_stage   = spc_pkg::HOME_MAX;
      mismatches   = 0;
    endfunction

    function void write_reg(spc_pkg::reg_idx_t idx, logic [31:0] data);
      case (idx)
        spc_pkg::REG_START_PERIOD: start_period = data[15:0];
        spc_pkg::REG_RUN_PERIOD:   run_period   = data[15:0];
        spc_pkg::REG_PHASE_COUNT:  phase_count  = data[3:0];
        spc_pkg::REG_PATTERN:      pattern      = data;
        spc_pkg::REG_MAX_POS:      max_pos      = data[15:0];
        spc_pkg::REG_MIN_POS:      min_pos      = data[15:0];
        spc_pkg::REG_ORIGIN_POS:   origin_pos   = data[15:0];
        default: ;
      endcase
    endfunction

    // one step tick: count toward the period, then move one step
    function void step_motor();
      logic [3:0] n;
      logic       due;
      n = (phase_count == 0) ? 4'd1 :
          (phase_count > spc_pkg::PHASES_MAX) ? spc_pkg::PHASES_MAX : phase_count;
      if (cur_pos == tgt_pos) begin
        tick   = '0;
        steps  = '0;
        dir    = spc_pkg::DIR_STOP;
        moving = 1'b0;
        coil   = '0;
        return;
      end
      if (tick != spc_pkg::TICK_MAX) tick++;
      due = (steps <= spc_pkg::START_LAST) ? (tick > start_period) : (tick > run_period);
      if (!due) return;
      tick = '0;
      if (steps != spc_pkg::STEPS_MAX) steps++;
      if (tgt_pos < cur_pos) begin
        dir = spc_pkg::DIR_REV;
        cur_pos--;
        if (phase != 0) phase--;
        else phase = 3'(n - 1);
      end else begin
        dir = spc_pkg::DIR_FWD;
        cur_pos++;
        if ({1'b0, phase} < n - 1) phase++;
        else phase = '0;
      end
      moving = 1'b1;
      coil   = pattern[4*phase +: 4];
    endfunction

    // one homing tick: aim at the current stop, or advance the stage there
    function void home_motor();
      spc_pkg::pos_t stop;
      if (!homing_on) return;
      if (home_stage == spc_pkg::HOME_MAX) stop = max_pos;
      else if (home_stage == spc_pkg::HOME_MIN) stop = min_pos;
      else stop = origin_pos;
      if (cur_pos != stop) tgt_pos = stop;
      else if (home_stage < spc_pkg::HOME_ORIGIN) home_stage++;
      else homing_on = 1'b0;
    endfunction

    function void note_command(logic [2:0] cmd, spc_pkg::pos_t val, logic frc);
      int      sum;
      status_t s;
      case (cmd)
        spc_pkg::CMD_STEP_TICK:  step_motor();
        spc_pkg::CMD_SET_TARGET: if (frc || !moving) tgt_pos = val;
        spc_pkg::CMD_STOP:       tgt_pos = cur_pos;
        spc_pkg::CMD_OFFSET: begin
          sum = int'(tgt_pos) + int'(val);
          if (sum > int'(max_pos)) sum = int'(max_pos);
          else if (sum < int'(min_pos)) sum = int'(min_pos);
          tgt_pos = spc_pkg::pos_t'(sum);
          cur_pos = tgt_pos;
        end
        spc_pkg::CMD_HOME_START: begin
          homing_on  = 1'b1;
          home_stage = spc_pkg::HOME_MAX;
        end
        spc_pkg::CMD_HOME_ABORT: homing_on = 1'b0;
        spc_pkg::CMD_HOME_TICK:  home_motor();
        default: ;
      endcase
      s.pad       = '0;
      s.stage     = home_stage;
      s.homing    = homing_on;
      s.target    = tgt_pos;
      s.position  = cur_pos;
      s.direction = dir;
      s.running   = moving;
      s.coil      = coil;
      pending_status.push_back(s);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want === got) return;
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_status(logic [spc_pkg::OUT_DATA_BITS-1:0] raw);
      status_t got;
      status_t want;
      got = status_t'(raw);
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, raw);
        return;
      end
      want = pending_status.pop_front();
      compare("coil_pattern",  16'(want.coil),      16'(got.coil));
      compare("running",       16'(want.running),   16'(got.running));
      compare("direction",     16'(want.direction), 16'(got.direction));
      compare("position",      want.position,       got.position);
      compare("target",        want.target,         got.target);
      compare("homing_active", 16'(want.homing),    16'(got.homing));
      compare("homing_stage",  16'(want.stage),     16'(got.stage));
      compare("padding",       16'(want.pad),       16'(got.pad));
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [spc_pkg::IN_DATA_BITS-1:0]  s_tdata = '0;
  logic [spc_pkg::CMD_BITS-1:0]      s_tuser = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [spc_pkg::OUT_DATA_BITS-1:0] m_tdata;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [spc_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [spc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  motion_tracker tracker = new();
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int            hold_cycles = 0;
  int unsigned   cycle_count = 0;
  int unsigned   commands_sent = 0;
  logic [15:0]   phase_start = '0;

  stepper_position_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // cycle budget
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: long hold when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready = 1'b0;
      hold_cycles--;
    end else begin
      m_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each accepted result item
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_status(m_tdata);
  end

  function automatic spc_pkg::pos_t fit_pos(int v);
    if (v > 32767) return spc_pkg::pos_t'(32767);
    if (v < -32768) return spc_pkg::pos_t'(-32768);
    return spc_pkg::pos_t'(v);
  endfunction

  task automatic send_command(logic [2:0] cmd, spc_pkg::pos_t val, logic frc);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {7'd0, frc, val};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_command(cmd, val, frc);
    commands_sent++;
  endtask

  task automatic write_register(spc_pkg::reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drop valid and wait for every outstanding result, then idle before returning
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_noise();
    logic [2:0]    cmd;
    spc_pkg::pos_t val;
    cmd = 3'($urandom_range(0, CMD_UNUSED));
    if ($urandom_range(1)) val = spc_pkg::pos_t'($urandom);
    else val = spc_pkg::pos_t'(int'($urandom_range(0, 40)) - 20);
    send_command(cmd, val, 1'($urandom));
  endtask

  task automatic configure_phase(int p);
    int         base;
    int         hi;
    int         lo;
    int         swap;
    logic [3:0] pc;
    base = int'(tracker.cur_pos);
    hi   = base + int'($urandom_range(3, 40));
    lo   = base - int'($urandom_range(3, 40));
    if (p == 3) begin
      hi = 32767;
      lo = -32768;
    end
    // inverted limits
    if (p == 5) begin
      swap = hi;
      hi   = lo;
      lo   = swap;
    end
    phase_start = (p == 1) ? 16'd0 : 16'($urandom_range(0, 3));
    if (p == 2) pc = 4'd0;
    else if (p == 6) pc = 4'hF;
    else pc = 4'($urandom_range(1, 8));
    write_register(spc_pkg::REG_START_PERIOD, {16'd0, phase_start});
    write_register(spc_pkg::REG_RUN_PERIOD,
                   {16'd0, 16'((p == 1) ? 0 : $urandom_range(0, 2))});
    write_register(spc_pkg::REG_PHASE_COUNT, {28'd0, pc});
    write_register(spc_pkg::REG_PATTERN, $urandom);
    write_register(spc_pkg::REG_MAX_POS, {16'd0, fit_pos(hi)});
    write_register(spc_pkg::REG_MIN_POS, {16'd0, fit_pos(lo)});
    write_register(spc_pkg::REG_ORIGIN_POS,
                   {16'd0, fit_pos(base + int'($urandom_range(0, 10)) - 5)});
  endtask

  // set a target, then tick toward it with some noise mixed in
  task automatic run_move(int span);
    int n;
    if ($urandom_range(1)) span = -span;
    send_command(spc_pkg::CMD_SET_TARGET, fit_pos(int'(tracker.cur_pos) + span),
                 ($urandom_range(3) == 0));
    n = (span < 0 ? -span : span) * (int'(phase_start) + 1) + int'($urandom_range(0, 4));
    if (n > 24 && span < 200 && span > -200) n = 24;
    repeat (n) begin
      if ($urandom_range(99) < 8) send_noise();
      else send_command(spc_pkg::CMD_STEP_TICK, spc_pkg::pos_t'($urandom), 1'($urandom));
    end
  endtask

  // homing: tick the sequence and step to each stop, abort now and then
  task automatic run_homing();
    int budget;
    budget = 60;
    send_command(spc_pkg::CMD_HOME_START, spc_pkg::pos_t'($urandom), 1'($urandom));
    while (tracker.homing_on && budget > 0) begin
      if ($urandom_range(99) < 3) begin
        send_command(spc_pkg::CMD_HOME_ABORT, spc_pkg::pos_t'($urandom), 1'($urandom));
      end else begin
        send_command(spc_pkg::CMD_HOME_TICK, spc_pkg::pos_t'($urandom), 1'($urandom));
        while (tracker.cur_pos != tracker.tgt_pos && budget > 0) begin
          send_command(spc_pkg::CMD_STEP_TICK, spc_pkg::pos_t'($urandom), 1'($urandom));
          budget--;
        end
      end
      budget--;
    end
  endtask

  initial begin
    int unsigned first;
    int unsigned pick;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed pass: extremes of limits and values, every command
    write_register(spc_pkg::REG_START_PERIOD, 32'd0);
    write_register(spc_pkg::REG_RUN_PERIOD, 32'd0);
    write_register(spc_pkg::REG_PHASE_COUNT, 32'd4);
    write_register(spc_pkg::REG_PATTERN, 32'h8765_4321);
    write_register(spc_pkg::REG_MAX_POS, 32'h0000_7FFF);
    write_register(spc_pkg::REG_MIN_POS, 32'h0000_8000);
    write_register(spc_pkg::REG_ORIGIN_POS, 32'h0000_8000);
    send_command(CMD_UNUSED, 16'hFFFF, 1'b1);
    send_command(spc_pkg::CMD_STEP_TICK, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_SET_TARGET, 16'd3, 1'b0);
    repeat (4) send_command(spc_pkg::CMD_STEP_TICK, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_SET_TARGET, -16'sd2, 1'b0);
    send_command(spc_pkg::CMD_STEP_TICK, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_SET_TARGET, 16'h7FFF, 1'b0);
    send_command(spc_pkg::CMD_SET_TARGET, 16'h8000, 1'b0);
    send_command(spc_pkg::CMD_SET_TARGET, 16'd100, 1'b1);
    send_command(spc_pkg::CMD_STEP_TICK, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_STOP, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_STEP_TICK, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_OFFSET, 16'h7FFF, 1'b0);
    send_command(spc_pkg::CMD_OFFSET, 16'h8000, 1'b0);
    send_command(spc_pkg::CMD_OFFSET, 16'h8000, 1'b0);
    send_command(spc_pkg::CMD_HOME_TICK, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_HOME_START, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_HOME_TICK, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_HOME_ABORT, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_STOP, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_STEP_TICK, 16'd0, 1'b0);
    send_command(spc_pkg::CMD_OFFSET, 16'h0040, 1'b1);
    settle();

    // randomized phases; idling follows the phase number
    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      send_idle_pct  = (p % 4 == 1) ? 57 : (p % 4 == 3) ? 16 : 0;
      recv_stall_pct = (p % 4 == 2) ? 57 : (p % 4 == 3) ? 16 : 0;
      // hold the result side off so the block backs up its input
      if (p == 0) hold_cycles = 60;
      first = commands_sent;
      // one long move that can saturate the step count
      if (p == 1) run_move(262);
      while (commands_sent - first < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 50) run_move(int'($urandom_range(1, 30)));
        else if (pick < 70) run_homing();
        else repeat ($urandom_range(1, 4)) send_noise();
      end
      settle();
    end

    // drain
    @(negedge clk);
    s_tvalid = 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
